@@ rtl/calc_pkg.sv @@
// Shared types, codes and microprogram ROM for the keypad calculator.
// No dependencies; imported by keypad_four_function_calculator.
package calc_pkg;

	localparam int STEP_W = 4;

	localparam logic [1:0] ACT_DIGIT  = 2'd0;
	localparam logic [1:0] ACT_OPER   = 2'd1;
	localparam logic [1:0] ACT_EQUALS = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_NONE = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [3:0] DIV_LAST  = 4'd15;
	localparam logic [2:0] POW_LAST  = 3'd4;
	localparam logic [2:0] POW_END   = 3'd5;

	localparam logic [STEP_W-1:0] S_FETCH    = 4'd0;
	localparam logic [STEP_W-1:0] S_DISPATCH = 4'd1;
	localparam logic [STEP_W-1:0] S_CALC     = 4'd2;
	localparam logic [STEP_W-1:0] S_DIVSTEP  = 4'd3;
	localparam logic [STEP_W-1:0] S_DIVFIX   = 4'd4;
	localparam logic [STEP_W-1:0] S_CONV     = 4'd5;
	localparam logic [STEP_W-1:0] S_MINUS    = 4'd6;
	localparam logic [STEP_W-1:0] S_SUB      = 4'd7;
	localparam logic [STEP_W-1:0] S_EMIT     = 4'd8;
	localparam logic [STEP_W-1:0] S_NEXT     = 4'd9;
	localparam logic [STEP_W-1:0] S_DONE     = 4'd10;

	typedef enum logic [3:0] {
		U_NOP,
		U_FETCH,
		U_KEY,
		U_CALC,
		U_DIV,
		U_DIVFIX,
		U_CONV,
		U_EMIT_MINUS,
		U_SUB,
		U_EMIT_DIG
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_NOT_EQUALS,
		C_NOT_DIV,
		C_DIV_MORE,
		C_POSITIVE,
		C_WAIT,
		C_GE,
		C_MORE_POW
	} cond_t;

	typedef struct packed {
		uop_t              uop;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t cw;
		case (step)
			S_FETCH:    cw = '{U_FETCH,      C_NO_ACCEPT,  S_FETCH};
			S_DISPATCH: cw = '{U_KEY,        C_NOT_EQUALS, S_FETCH};
			S_CALC:     cw = '{U_CALC,       C_NOT_DIV,    S_CONV};
			S_DIVSTEP:  cw = '{U_DIV,        C_DIV_MORE,   S_DIVSTEP};
			S_DIVFIX:   cw = '{U_DIVFIX,     C_NEVER,      S_FETCH};
			S_CONV:     cw = '{U_CONV,       C_POSITIVE,   S_SUB};
			S_MINUS:    cw = '{U_EMIT_MINUS, C_WAIT,       S_MINUS};
			S_SUB:      cw = '{U_SUB,        C_GE,         S_SUB};
			S_EMIT:     cw = '{U_EMIT_DIG,   C_WAIT,       S_EMIT};
			S_NEXT:     cw = '{U_NOP,        C_MORE_POW,   S_SUB};
			S_DONE:     cw = '{U_NOP,        C_ALWAYS,     S_FETCH};
			default:    cw = '{U_NOP,        C_ALWAYS,     S_FETCH};
		endcase
		return cw;
	endfunction

	function automatic logic [15:0] pow10(input logic [2:0] idx);
		logic [15:0] p;
		case (idx)
			3'd0:    p = 16'd10000;
			3'd1:    p = 16'd1000;
			3'd2:    p = 16'd100;
			3'd3:    p = 16'd10;
			default: p = 16'd1;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/keypad_four_function_calculator.sv @@
// Keypad four-function calculator: microcoded sequencer and datapath.
// Depends on calc_pkg (control words, codes, power-of-ten table).
//
// Usage:
//   Input channel s_*: one keypad word per handshake. s_tdata holds action
//   (digit, operator, equals, clear), the digit value and the operation code.
//   Output channel m_*: one ASCII character per word; m_tlast marks the final
//   character of a result, m_tdata also carries the signed 16-bit result and
//   m_tuser the divide-by-zero flag, both constant across the run.
//   Digit, operator and clear keys produce no output; each passes through
//   the fetch and dispatch steps. Equals runs the calculate step, then for
//   a division 16 restoring divide steps and a sign fix, then a minus sign
//   if the result is negative, then repeated subtraction, up to 9 for each
//   of the five decimal places.
//   One key is processed at a time; s_tready is high only in the fetch step.
//   Results leave through a single output register, so the sequencer keeps
//   working while a character waits and stalls only at its next emit step
//   when m_tready is low.
//   Reset clears the entry, digit count and first operand and leaves no
//   operator stored; equals then yields "0". There is no clearing pass.
module keypad_four_function_calculator #(
	parameter int MAX_DIGITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // action[1:0], digit[5:2], operation[7:6]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // char_code[7:0], value[23:8]
	output logic        m_tlast,
	output logic        m_tuser    // div_zero[0]
);
	import calc_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic [STEP_W-1:0] pc_q;
	ctrl_t             cw;

	logic [1:0]       act_q;
	logic [3:0]       digit_q;
	logic [1:0]       oper_q;
	logic [15:0]      entry_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      first_q;
	logic [2:0]       op_q;

	logic [15:0] res_q;
	logic        dz_q;
	logic        qneg_q;
	logic [15:0] dvd_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic [3:0]  cnt_q;

	logic [15:0] mag_q;
	logic [2:0]  pow_q;
	logic [3:0]  dig_q;
	logic        started_q;

	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;
	logic [15:0] out_value_q;
	logic        out_dz_q;

	logic        accept;
	logic        out_free;
	logic [15:0] pow_val;
	logic        mag_ge;
	logic        emit_now;
	logic        emit_req;
	logic        wait_out;
	logic        emit_fire;
	logic        cond_hit;
	logic [15:0] a_mag;
	logic [15:0] b_mag;
	logic [31:0] product;
	logic [15:0] entry_next;
	logic [16:0] trial;

	assign cw       = ucode(pc_q);
	assign s_tready = (cw.uop == U_FETCH);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign pow_val  = pow10(pow_q);
	assign mag_ge   = (mag_q >= pow_val);
	assign emit_now = started_q || (dig_q != 4'd0) || (pow_q == POW_LAST);
	assign emit_req = (cw.uop == U_EMIT_MINUS) || ((cw.uop == U_EMIT_DIG) && emit_now);
	assign wait_out = emit_req && !out_free;
	assign emit_fire = emit_req && out_free;

	assign a_mag   = first_q[15] ? 16'(-first_q) : first_q;
	assign b_mag   = entry_q[15] ? 16'(-entry_q) : entry_q;
	assign product = first_q * entry_q;
	assign entry_next = {entry_q[12:0], 3'b000} + {entry_q[14:0], 1'b0} + {12'd0, digit_q};
	assign trial   = {rem_q, dvd_q[15]} - {1'b0, dvs_q};

	always_comb begin
		case (cw.cond)
			C_NEVER:      cond_hit = 1'b0;
			C_ALWAYS:     cond_hit = 1'b1;
			C_NO_ACCEPT:  cond_hit = !accept;
			C_NOT_EQUALS: cond_hit = (act_q != ACT_EQUALS);
			C_NOT_DIV:    cond_hit = (op_q != OP_DIV);
			C_DIV_MORE:   cond_hit = (cnt_q != DIV_LAST);
			C_POSITIVE:   cond_hit = !res_q[15];
			C_WAIT:       cond_hit = wait_out;
			C_GE:         cond_hit = mag_ge;
			C_MORE_POW:   cond_hit = (pow_q != POW_END);
			default:      cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= S_FETCH;
			entry_q     <= '0;
			count_q     <= '0;
			first_q     <= '0;
			op_q        <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_hit ? cw.target : STEP_W'(pc_q + 1'b1);

			case (cw.uop)
				U_FETCH: begin
					if (accept) begin
						act_q   <= s_tdata[1:0];
						digit_q <= s_tdata[5:2];
						oper_q  <= s_tdata[7:6];
					end
				end
				U_KEY: begin
					case (act_q)
						ACT_DIGIT: begin
							if (digit_q <= DIGIT_MAX && count_q < CNT_W'(MAX_DIGITS)) begin
								entry_q <= entry_next;
								count_q <= count_q + 1'b1;
							end
						end
						ACT_OPER: begin
							first_q <= entry_q;
							op_q    <= {1'b0, oper_q};
							entry_q <= '0;
							count_q <= '0;
						end
						ACT_CLEAR: begin
							entry_q <= '0;
							count_q <= '0;
						end
						default: ;
					endcase
				end
				U_CALC: begin
					dz_q <= 1'b0;
					case (op_q)
						OP_ADD: res_q <= first_q + entry_q;
						OP_SUB: res_q <= first_q - entry_q;
						OP_MUL: res_q <= product[15:0];
						OP_DIV: begin
							dz_q   <= (entry_q == 16'd0);
							qneg_q <= first_q[15] ^ entry_q[15];
							dvd_q  <= a_mag;
							dvs_q  <= b_mag;
							rem_q  <= '0;
							cnt_q  <= '0;
						end
						default: res_q <= '0;
					endcase
				end
				U_DIV: begin
					if (!trial[16]) begin
						rem_q <= trial[15:0];
						dvd_q <= {dvd_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[14:0], dvd_q[15]};
						dvd_q <= {dvd_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				U_DIVFIX: begin
					res_q <= dz_q ? 16'd0 : (qneg_q ? 16'(-dvd_q) : dvd_q);
				end
				U_CONV: begin
					entry_q   <= '0;
					count_q   <= '0;
					first_q   <= '0;
					mag_q     <= res_q[15] ? 16'(-res_q) : res_q;
					pow_q     <= '0;
					dig_q     <= '0;
					started_q <= 1'b0;
				end
				U_SUB: begin
					if (mag_ge) begin
						mag_q <= mag_q - pow_val;
						dig_q <= dig_q + 1'b1;
					end
				end
				U_EMIT_DIG: begin
					if (!wait_out) begin
						started_q <= started_q || emit_now;
						dig_q     <= '0;
						pow_q     <= pow_q + 1'b1;
					end
				end
				default: ;
			endcase

			if (emit_fire) begin
				out_valid_q <= 1'b1;
				out_value_q <= res_q;
				out_dz_q    <= dz_q;
				if (cw.uop == U_EMIT_MINUS) begin
					out_char_q <= CH_MINUS;
					out_last_q <= 1'b0;
				end else begin
					out_char_q <= CH_ZERO + {4'd0, dig_q};
					out_last_q <= (pow_q == POW_LAST);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_value_q, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_dz_q;

	a_fetch_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sequencer stayed in fetch after taking a key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond limit");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] >= CH_ZERO && m_tdata[7:0] <= CH_NINE)
		else $error("final character is not a decimal digit");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !emit_fire)
		else $error("output register overwritten while stalled");

endmodule
